@@ hw/rtl/mwf_pkg.sv @@
// Package: shared constants, function codes, stage records and byte-mask helper.
`default_nettype none
package mwf_pkg;

    localparam int BYTE_BITS      = 6;
    localparam int BYTES_PER_WORD = 5;
    localparam int MAG_BITS       = BYTE_BITS * BYTES_PER_WORD;
    localparam int VAL_BITS       = MAG_BITS + 1;
    localparam int ADDR_BITS      = 16;
    localparam int SPEC_BITS      = 6;
    localparam int POS_BITS       = 3;
    localparam int BASE_BITS      = 2 * BYTE_BITS;

    // function codes
    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_VALUE = 2'd1;
    localparam logic [1:0] FUNC_ADDR  = 2'd2;

    localparam logic [POS_BITS-1:0] LAST_BYTE = POS_BITS'(BYTES_PER_WORD);

    // decode stage record
    typedef struct packed {
        logic                  valid;
        logic [1:0]            func;
        logic                  sign;
        logic                  old_sign;
        logic                  sign_in_field;
        logic                  empty;
        logic [POS_BITS-1:0]   shift_bytes;
        logic [POS_BITS-1:0]   count;
        logic [MAG_BITS-1:0]   mag;
        logic [BASE_BITS-1:0]  base;
        logic [BYTE_BITS-1:0]  ix;
    } dec_t;

    // extract stage record
    typedef struct packed {
        logic                  valid;
        logic [1:0]            func;
        logic                  load_sign;
        logic                  negate;
        logic [MAG_BITS-1:0]   part;
        logic [ADDR_BITS-1:0]  addr;
    } ext_t;

    // mask of the low count bytes
    function automatic logic [MAG_BITS-1:0] byte_mask(input logic [POS_BITS-1:0] count);
        logic [MAG_BITS-1:0] m;
        m = '0;
        for (int i = 0; i < BYTES_PER_WORD; i++)
        begin
            if (POS_BITS'(i) < count)
            begin
                m[i*BYTE_BITS +: BYTE_BITS] = '1;
            end
        end
        return m;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/mix_word_field_unit.sv @@
// Top level of the MIX word field unit: three-stage decode / extract / format pipeline.
//
//   channel   signals                                              qualifier
//   request   func word_sign word_magnitude field_spec old_sign    start && !busy
//   result    result_sign result_magnitude field_value address     done (one cycle)
//
// One request per cycle; the request is registered in turn by the decode, extract and format
// stage registers, and done rises together with the result in the format register.
// Reset (rst_n, asynchronous) clears the decode and extract stages and the done strobe.
// No stage ever stalls: busy stays low and done is a single-cycle strobe.
`default_nettype none
module mix_word_field_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [1:0]                     func,
    input  wire logic                           word_sign,
    input  wire logic [mwf_pkg::MAG_BITS-1:0]   word_magnitude,
    input  wire logic [mwf_pkg::SPEC_BITS-1:0]  field_spec,
    input  wire logic                           old_sign,
    output logic                                done,
    output logic                                result_sign,
    output logic [mwf_pkg::MAG_BITS-1:0]        result_magnitude,
    output logic signed [mwf_pkg::VAL_BITS-1:0] field_value,
    output logic [mwf_pkg::ADDR_BITS-1:0]       address
);
    import mwf_pkg::*;

    dec_t dec;
    ext_t ext;
    logic req_valid;

    // pipeline always takes a request
    assign busy      = 1'b0;
    assign req_valid = start & ~busy;

    mwf_decode u_decode (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .func           (func),
        .word_sign      (word_sign),
        .word_magnitude (word_magnitude),
        .field_spec     (field_spec),
        .old_sign       (old_sign),
        .dec            (dec)
    );

    mwf_extract u_extract (
        .clk   (clk),
        .rst_n (rst_n),
        .dec   (dec),
        .ext   (ext)
    );

    mwf_format u_format (
        .clk              (clk),
        .rst_n            (rst_n),
        .ext              (ext),
        .done             (done),
        .result_sign      (result_sign),
        .result_magnitude (result_magnitude),
        .field_value      (field_value),
        .address          (address)
    );

endmodule
`default_nettype wire

@@ hw/rtl/mwf_decode.sv @@
// Stage 1: splits the field spec, works out the byte range and the address base.
`default_nettype none
module mwf_decode (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    input  wire logic [1:0]                    func,
    input  wire logic                          word_sign,
    input  wire logic [mwf_pkg::MAG_BITS-1:0]  word_magnitude,
    input  wire logic [mwf_pkg::SPEC_BITS-1:0] field_spec,
    input  wire logic                          old_sign,
    output mwf_pkg::dec_t                      dec
);
    import mwf_pkg::*;

    dec_t               dec_reg;
    dec_t               dec_next;
    logic [POS_BITS-1:0] left;
    logic [POS_BITS-1:0] right_raw;
    logic [POS_BITS-1:0] right;
    logic [POS_BITS-1:0] first;

    // field bounds
    always_comb
    begin
        left      = field_spec[SPEC_BITS-1 -: POS_BITS];
        right_raw = field_spec[POS_BITS-1:0];
        right     = (right_raw > LAST_BYTE) ? LAST_BYTE : right_raw;
        first     = (left == '0) ? POS_BITS'(1) : left;

        dec_next.valid         = req_valid;
        dec_next.func          = func;
        dec_next.sign          = word_sign;
        dec_next.old_sign      = old_sign;
        dec_next.sign_in_field = (left == '0);
        dec_next.empty         = (first > right);
        dec_next.shift_bytes   = LAST_BYTE - right;
        dec_next.count         = right - first + POS_BITS'(1);
        dec_next.mag           = word_magnitude;
        dec_next.base          = word_magnitude[MAG_BITS-1 -: BASE_BITS];
        dec_next.ix            = word_magnitude[MAG_BITS-BASE_BITS-1 -: BYTE_BITS];
    end

    // stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_reg <= '0;
        end
        else
        begin
            dec_reg <= dec_next;
        end
    end

    assign dec = dec_reg;

endmodule
`default_nettype wire

@@ hw/rtl/mwf_extract.sv @@
// Stage 2: byte shift and mask of the field, signed address sum.
`default_nettype none
module mwf_extract (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire mwf_pkg::dec_t dec,
    output mwf_pkg::ext_t ext
);
    import mwf_pkg::*;

    ext_t                 ext_reg;
    ext_t                 ext_next;
    logic [MAG_BITS-1:0]  shifted;
    logic [ADDR_BITS-1:0] base_ext;
    logic [ADDR_BITS-1:0] base_signed;

    // right-align the last byte of the field
    always_comb
    begin
        case (dec.shift_bytes)
            3'd0:    shifted = dec.mag;
            3'd1:    shifted = dec.mag >> BYTE_BITS;
            3'd2:    shifted = dec.mag >> (2 * BYTE_BITS);
            3'd3:    shifted = dec.mag >> (3 * BYTE_BITS);
            3'd4:    shifted = dec.mag >> (4 * BYTE_BITS);
            default: shifted = '0;
        endcase
    end

    // mask, address, pass-through
    always_comb
    begin
        base_ext    = ADDR_BITS'(dec.base);
        base_signed = dec.sign ? (ADDR_BITS'(0) - base_ext) : base_ext;

        ext_next.valid     = dec.valid;
        ext_next.func      = dec.func;
        ext_next.load_sign = dec.sign_in_field ? dec.sign : dec.old_sign;
        ext_next.negate    = dec.sign_in_field & dec.sign;
        ext_next.part      = dec.empty ? '0 : (shifted & byte_mask(dec.count));
        ext_next.addr      = base_signed + ADDR_BITS'(dec.ix);
    end

    // stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg <= '0;
        end
        else
        begin
            ext_reg <= ext_next;
        end
    end

    assign ext = ext_reg;

endmodule
`default_nettype wire

@@ hw/rtl/mwf_format.sv @@
// Stage 3: sign application and per-function result selection into the output register.
`default_nettype none
module mwf_format (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire mwf_pkg::ext_t                 ext,
    output logic                               done,
    output logic                               result_sign,
    output logic [mwf_pkg::MAG_BITS-1:0]       result_magnitude,
    output logic signed [mwf_pkg::VAL_BITS-1:0] field_value,
    output logic [mwf_pkg::ADDR_BITS-1:0]      address
);
    import mwf_pkg::*;

    logic                 done_reg;
    logic                 sign_reg,  sign_next;
    logic [MAG_BITS-1:0]  mag_reg,   mag_next;
    logic [VAL_BITS-1:0]  val_reg,   val_next;
    logic [ADDR_BITS-1:0] addr_reg,  addr_next;
    logic [VAL_BITS-1:0]  part_ext;

    // result select; unused code gives all zeros
    always_comb
    begin
        part_ext  = VAL_BITS'(ext.part);
        sign_next = 1'b0;
        mag_next  = '0;
        val_next  = '0;
        addr_next = '0;
        case (ext.func)
            FUNC_LOAD:
            begin
                sign_next = ext.load_sign;
                mag_next  = ext.part;
            end
            FUNC_VALUE:
            begin
                val_next = ext.negate ? (VAL_BITS'(0) - part_ext) : part_ext;
            end
            FUNC_ADDR:
            begin
                addr_next = ext.addr;
            end
            default:
            begin
                sign_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ext.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        sign_reg <= sign_next;
        mag_reg  <= mag_next;
        val_reg  <= val_next;
        addr_reg <= addr_next;
    end

    assign done             = done_reg;
    assign result_sign      = sign_reg;
    assign result_magnitude = mag_reg;
    assign field_value      = signed'(val_reg);
    assign address          = addr_reg;

endmodule
`default_nettype wire
